/* design/string_dictionary_lookup_macros.svh */
// assertion macros for the string dictionary lookup block
// used by the top level; no other dependencies
`ifndef STRING_DICTIONARY_LOOKUP_MACROS_SVH
`define STRING_DICTIONARY_LOOKUP_MACROS_SVH
// property must hold at every edge outside reset
`define SDL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen at an edge outside reset
`define SDL_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

/* design/sdl_pkg.sv */
// package for the string dictionary lookup block: sizes, codes, payload types,
// the hash power table functions; no dependencies
package sdl_pkg;
   localparam int HASH_BITS       = 12;
   localparam int MAX_WORDS_DEF   = 4096;
   localparam int POOL_BYTES_DEF  = 65536;
   localparam int MAX_KEY_LEN_DEF = 64;
   localparam int POWER_DEPTH     = 3072;

   localparam logic [2:0] CMD_BUCKET = 3'd0;
   localparam logic [2:0] CMD_WADDR  = 3'd1;
   localparam logic [2:0] CMD_POOL   = 3'd2;
   localparam logic [2:0] CMD_COUNT  = 3'd3;
   localparam logic [2:0] CMD_QUERY  = 3'd4;

   localparam logic [1:0] REG_HASH_MASK = 2'd0;

   typedef struct packed {
      logic [2:0]         command;
      logic [15:0]        entry_index;
      logic [31:0]        entry_value;
      logic signed [7:0]  key_byte;
      logic               key_last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [12:0] word_number;
      logic [31:0] stored_count;
      logic        key_too_long;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BKT0, ST_BKT1, ST_BKT2, ST_PICK, ST_WA, ST_WA2,
      ST_CMP, ST_CMP2, ST_DECIDE, ST_CNT, ST_CNT2, ST_DONE
   } state_type;

   // low 12 bits of 331^(u+1), u is the key byte offset by 128
   function automatic logic [11:0] power_byte(input logic [7:0] u);
      logic [11:0] p, r;
      p = 12'd1;
      r = 12'd1;
      for (int i = 0; i < 256; i++) begin
         p = 12'(p * 12'd331);
         if (i == int'(u)) r = p;
      end
      return r;
   endfunction

   // low 12 bits of 331^(256*pos), pos is the position mod 12
   function automatic logic [11:0] power_pos(input logic [3:0] pos);
      logic [11:0] p, stride, r;
      stride = 12'd1;
      for (int i = 0; i < 256; i++) stride = 12'(stride * 12'd331);
      p = 12'd1;
      r = 12'd1;
      for (int i = 0; i < 12; i++) begin
         if (i == int'(pos)) r = p;
         p = 12'(p * stride);
      end
      return r;
   endfunction
endpackage

/* design/sdl_ram.sv */
// generic single-port synchronous ram with registered read
// no dependencies
module sdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

/* design/sdl_hash.sv */
// key gather and hash: buffers key bytes into the key ram and keeps the masked sum
// depends on sdl_pkg
module sdl_hash import sdl_pkg::*; #(
   parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_en,
   input  logic [7:0]                     key_byte,
   input  logic                           clear,
   output logic                           kb_wr,
   output logic [$clog2(MAX_KEY_LEN)-1:0] kb_addr,
   output logic [HASH_BITS-1:0]           hash,
   output logic [$clog2(MAX_KEY_LEN+1)-1:0] key_len,
   output logic                           overflow
);
   localparam int LW = $clog2(MAX_KEY_LEN+1);
   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [3:0]           pos_ff, pos_in;
   logic                 ovf_ff, ovf_in;
   logic [11:0]          term;

   always_comb begin
      // 331^(129+256*pos+b) split into a position factor and a byte factor
      term = 12'(power_pos(pos_ff) * power_byte(key_byte ^ 8'h80));
      hash_in = hash_ff; len_in = len_ff; pos_in = pos_ff; ovf_in = ovf_ff;
      kb_wr = 1'b0;
      if (clear) begin
         hash_in = '0; len_in = '0; pos_in = '0; ovf_in = 1'b0;
      end else if (byte_en && key_byte != 8'd0) begin
         hash_in = HASH_BITS'(({20'd0, hash_ff} + {20'd0, term}) & 32'hFFF);
         if (int'(len_ff) < MAX_KEY_LEN) begin
            kb_wr = 1'b1; len_in = LW'(len_ff + 1'b1);
         end else ovf_in = 1'b1;
         pos_in = (pos_ff >= 4'd11) ? 4'd0 : 4'(pos_ff + 1'b1);
      end
   end
   assign kb_addr  = len_ff[$clog2(MAX_KEY_LEN)-1:0];
   assign hash     = hash_ff;
   assign key_len  = len_ff;
   assign overflow = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0; len_ff <= '0; pos_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in; len_ff <= len_in; pos_ff <= pos_in; ovf_ff <= ovf_in;
      end
   end
endmodule

/* design/string_dictionary_lookup.sv */
// Static string dictionary lookup. Load commands (bucket start, word address,
// pool byte, word count) and key bytes are each accepted while the block is
// idle. On the last key byte the block reads the bucket bounds and searches the
// bucket with string compares from the pool memory: each pool byte compare
// waits on a registered ram read, a word probe reads the word address and then
// compares at most key length+1 bytes, and a query runs its probes after the
// bucket bounds and reads the stored count on a hit; an overlong key skips the
// search. One transaction is worked on at a time; the result waits in an
// output register and the input stalls until it is taken.
// depends on sdl_pkg, sdl_ram, sdl_hash and the macros header
`include "string_dictionary_lookup_macros.svh"
module string_dictionary_lookup import sdl_pkg::*; #(
   parameter int MAX_WORDS   = MAX_WORDS_DEF,
   parameter int POOL_BYTES  = POOL_BYTES_DEF,
   parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int BD = (1 << HASH_BITS) + 1;
   localparam int BA = $clog2(BD);
   localparam int WA = $clog2(MAX_WORDS);
   localparam int PA = $clog2(POOL_BYTES);
   localparam int KA = $clog2(MAX_KEY_LEN);
   localparam int LW = $clog2(MAX_KEY_LEN+1);

   logic [11:0] mask_ff;
   state_type   st_ff, st_in;
   logic        acc, busy;
   logic        is_load;

   assign csr_pready = 1'b1;
   assign csr_prdata = {20'd0, mask_ff};
   always_ff @(posedge clock) begin
      if (reset) mask_ff <= 12'hFFF;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_HASH_MASK)
         mask_ff <= csr_pwdata[11:0];
   end

   assign busy = (st_ff != ST_IDLE) || rsp_valid;
   assign req_stall = busy;
   assign acc = req_valid && !busy;
   assign is_load = acc;

   // hash unit
   logic           kb_wr, ovf, hclear;
   logic [KA-1:0]  kb_waddr;
   logic [HASH_BITS-1:0] hash;
   logic [LW-1:0]  klen;
   sdl_hash #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_hash (
      .clock, .reset, .byte_en(acc && req_data.command == CMD_QUERY),
      .key_byte(req_data.key_byte), .clear(hclear), .kb_wr, .kb_addr(kb_waddr),
      .hash, .key_len(klen), .overflow(ovf));

   // search registers
   logic [31:0]  lo_ff, lo_in, hi_ff, hi_in, probe_ff, probe_in;
   logic [1:0]   phase_ff, phase_in;   // 0 first, 1 last, 2 bisect, 3 pair second
   logic [PA-1:0] paddr_ff, paddr_in;
   logic [LW-1:0] ci_ff, ci_in;
   logic [1:0]   cres_ff, cres_in;     // 0 equal, 1 key less, 2 key greater
   logic [31:0]  hit_ff, hit_in;
   logic [31:0]  cnt_ff, cnt_in;

   // memories
   logic          b_we, w_we, p_we, c_we;
   logic [BA-1:0] b_a; logic [31:0] b_q;
   logic [WA-1:0] w_a; logic [PA-1:0] w_q;
   logic [PA-1:0] p_a; logic [7:0] p_q;
   logic [WA-1:0] c_a; logic [31:0] c_q;
   logic [KA-1:0] k_a; logic [7:0] k_q;

   sdl_ram #(.WIDTH(32), .DEPTH(BD)) u_bkt (.clock, .wr_en(b_we), .addr(b_a),
      .wr_data(req_data.entry_value), .rd_data(b_q));
   sdl_ram #(.WIDTH(PA), .DEPTH(MAX_WORDS)) u_wad (.clock, .wr_en(w_we), .addr(w_a),
      .wr_data(req_data.entry_value[PA-1:0]), .rd_data(w_q));
   sdl_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (.clock, .wr_en(p_we), .addr(p_a),
      .wr_data(req_data.entry_value[7:0]), .rd_data(p_q));
   sdl_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_cnt (.clock, .wr_en(c_we), .addr(c_a),
      .wr_data(req_data.entry_value), .rd_data(c_q));
   sdl_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_key (.clock, .wr_en(kb_wr), .addr(k_a),
      .wr_data(req_data.key_byte), .rd_data(k_q));

   logic [HASH_BITS-1:0] bidx;
   assign bidx = hash & mask_ff[HASH_BITS-1:0];
   logic [7:0] kch;
   assign kch = (ci_ff < klen) ? k_q : 8'd0;
   logic [31:0] span;
   assign span = hi_ff - lo_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (acc && req_data.command == CMD_QUERY && req_data.key_last)
                      st_in = ST_BKT0;
         ST_BKT0:  st_in = ovf ? ST_DONE : ST_BKT1;
         ST_BKT1:  st_in = ST_BKT2;
         ST_BKT2:  st_in = ST_PICK;
         ST_PICK:  st_in = (hi_ff <= lo_ff || hi_ff > 32'(MAX_WORDS)) ? ST_DONE : ST_WA;
         ST_WA:    st_in = ST_WA2;
         ST_WA2:   st_in = ST_CMP;
         ST_CMP:   st_in = ST_CMP2;
         ST_CMP2:  st_in = (kch != p_q || kch == 8'd0) ? ST_DECIDE : ST_CMP;
         ST_DECIDE: begin
            if (cres_ff == 2'd0) st_in = ST_CNT;
            else begin
               st_in = ST_DONE;
               unique case (phase_ff)
                  2'd0: if (cres_ff == 2'd2 && span >= 32'd2) st_in = ST_WA;
                  2'd3: ;
                  2'd1: if (cres_ff == 2'd1 && span > 32'd1) st_in = ST_WA;
                  default: if ((cres_ff == 2'd2 ? hi_ff - probe_ff : probe_ff - lo_ff)
                                 > 32'd1) st_in = ST_WA;
               endcase
            end
         end
         ST_CNT:   st_in = ST_CNT2;
         ST_CNT2:  st_in = ST_DONE;
         ST_DONE:  st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      lo_in = lo_ff; hi_in = hi_ff; probe_in = probe_ff;
      phase_in = phase_ff; paddr_in = paddr_ff; ci_in = ci_ff; cres_in = cres_ff;
      hit_in = hit_ff; cnt_in = cnt_ff; hclear = 1'b0;
      b_we = is_load && req_data.command == CMD_BUCKET && 32'(req_data.entry_index) < 32'(BD);
      w_we = is_load && req_data.command == CMD_WADDR && 32'(req_data.entry_index) < 32'(MAX_WORDS);
      p_we = is_load && req_data.command == CMD_POOL && 32'(req_data.entry_index) < 32'(POOL_BYTES);
      c_we = is_load && req_data.command == CMD_COUNT && 32'(req_data.entry_index) < 32'(MAX_WORDS);
      b_a = BA'(req_data.entry_index); w_a = WA'(req_data.entry_index);
      p_a = PA'(req_data.entry_index); c_a = WA'(req_data.entry_index);
      k_a = kb_waddr;
      unique case (st_ff)
         ST_BKT0: begin b_a = BA'(bidx); hit_in = '0; cnt_in = '0; end
         ST_BKT1: begin b_a = BA'({1'b0, bidx} + 1'b1); lo_in = b_q; end
         ST_BKT2: begin hi_in = b_q; end
         ST_PICK: begin probe_in = lo_ff; phase_in = 2'd0; end
         ST_WA: begin w_a = WA'(probe_ff); end
         ST_WA2: begin w_a = WA'(probe_ff); paddr_in = w_q; ci_in = '0; end
         ST_CMP: begin p_a = paddr_ff; k_a = KA'(ci_ff); end
         ST_CMP2: begin
            p_a = paddr_ff; k_a = KA'(ci_ff);
            if (kch != p_q) cres_in = (kch < p_q) ? 2'd1 : 2'd2;
            else if (kch == 8'd0) cres_in = 2'd0;
            paddr_in = PA'(paddr_ff + 1'b1); ci_in = LW'(ci_ff + 1'b1);
         end
         ST_DECIDE: begin
            if (cres_ff != 2'd0) begin
               unique case (phase_ff)
                  2'd0: if (span == 32'd2) begin probe_in = lo_ff + 1; phase_in = 2'd3; end
                        else begin hi_in = hi_ff - 1; probe_in = hi_ff - 1; phase_in = 2'd1; end
                  2'd3: ;
                  2'd1: begin phase_in = 2'd2; probe_in = lo_ff + ((hi_ff - lo_ff) >> 1); end
                  default: begin
                     if (cres_ff == 2'd2) begin lo_in = probe_ff;
                        probe_in = probe_ff + ((hi_ff - probe_ff) >> 1); end
                     else begin hi_in = probe_ff;
                        probe_in = lo_ff + ((probe_ff - lo_ff) >> 1); end
                  end
               endcase
            end else hit_in = probe_ff + 1;
         end
         ST_CNT: c_a = WA'(hit_ff - 1);
         ST_CNT2: cnt_in = c_q;
         ST_DONE: hclear = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE; else st_ff <= st_in;
      lo_ff <= lo_in; hi_ff <= hi_in; probe_ff <= probe_in;
      phase_ff <= phase_in; paddr_ff <= paddr_in; ci_ff <= ci_in; cres_ff <= cres_in;
      hit_ff <= hit_in; cnt_ff <= cnt_in;
   end

   // output register
   logic rv_ff;
   rsp_type rd_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (st_ff == ST_DONE) rv_ff <= 1'b1;
      else if (!rsp_stall) rv_ff <= 1'b0;
      if (st_ff == ST_DONE) begin
         rd_ff.found        <= (hit_ff != 0) && !ovf;
         rd_ff.word_number  <= ovf ? 13'd0 : hit_ff[12:0];
         rd_ff.stored_count <= (ovf || hit_ff == 0) ? 32'd0 : cnt_ff;
         rd_ff.key_too_long <= ovf;
      end
   end
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   `SDL_NEVER(a_no_acc_busy, clock, reset, req_valid && !req_stall && st_ff != ST_IDLE, "accept while searching")
   `SDL_ASSERT(a_done_sets_valid, clock, reset, st_ff == ST_DONE |=> rsp_valid, "result lost")
   `SDL_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_data.found |-> rsp_data.word_number == 13'd0, "miss with word number")
   `SDL_ASSERT(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")
endmodule
